// File: hw/rtl/csdfr_pkg.sv
// Shared constants, command and result types for the serial deframer.
`default_nettype none

package csdfr_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  // byte count saturates at PAYLOAD_DEPTH + 1
  localparam int BCNT_W        = $clog2(PAYLOAD_DEPTH + 2);
  // number of bytes emitted by one frame, 1 .. PAYLOAD_DEPTH
  localparam int ECNT_W        = $clog2(PAYLOAD_DEPTH + 1);

  localparam int CMDQ_DEPTH    = 4;
  localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_PTR_W    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE    = 2'd2;

  localparam logic [7:0] START_CODE_RST = 8'h80;
  localparam logic [7:0] STOP_CODE_RST  = 8'h81;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [6:0]        data;
    logic [ECNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [6:0] data;
    logic [5:0] index;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/csdfr_front.sv
// Front end: config registers, frame tracking, checksum check, command issue.
`default_nettype none

module csdfr_front
  import csdfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  byte_acc,
  input  wire logic [7:0]            rx_byte,
  output logic                       cmd_push,
  output cmd_t                       cmd
);

  logic              frame_enable_r;
  logic [7:0]        start_code_r;
  logic [7:0]        stop_code_r;

  logic              in_frame_r, in_frame_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [6:0]        chk_r, chk_nxt;
  logic [7:0]        sum_r, sum_nxt;

  logic [7:0]        sum_plus;
  logic [6:0]        expect_chk;

  assign sum_plus   = sum_r + 8'd1;
  assign expect_chk = ~sum_plus[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_enable_r <= 1'b0;
      start_code_r   <= START_CODE_RST;
      stop_code_r    <= STOP_CODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_ENABLE: frame_enable_r <= cfg_wdata[0];
        REG_START_CODE:   start_code_r   <= cfg_wdata;
        REG_STOP_CODE:    stop_code_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    bcnt_nxt     = bcnt_r;
    chk_nxt      = chk_r;
    sum_nxt      = sum_r;
    cmd_push     = 1'b0;
    cmd          = '0;
    if (byte_acc && frame_enable_r) begin
      if (rx_byte[7] && (rx_byte == start_code_r)) begin
        in_frame_nxt = 1'b1;
        bcnt_nxt     = '0;
        chk_nxt      = '0;
        sum_nxt      = '0;
      end else if (rx_byte[7] && (rx_byte == stop_code_r) && in_frame_r) begin
        in_frame_nxt = 1'b0;
        if ((chk_r == expect_chk) && (bcnt_r > BCNT_W'(1))) begin
          cmd_push  = 1'b1;
          cmd.op    = CMD_EMIT;
          cmd.count = ECNT_W'(bcnt_r - BCNT_W'(1));
        end
      end else if (!rx_byte[7] && in_frame_r) begin
        if (bcnt_r == '0) begin
          chk_nxt = rx_byte[6:0];
        end else begin
          cmd_push = 1'b1;
          cmd.op   = CMD_WRITE;
          cmd.data = rx_byte[6:0];
          // past capacity the last slot is overwritten
          if (bcnt_r > BCNT_W'(PAYLOAD_DEPTH)) begin
            cmd.addr = ADDR_W'(PAYLOAD_DEPTH - 1);
          end else begin
            cmd.addr = ADDR_W'(bcnt_r - BCNT_W'(1));
          end
          sum_nxt = sum_r + {1'b0, rx_byte[6:0]};
        end
        if (bcnt_r < BCNT_W'(PAYLOAD_DEPTH + 1)) begin
          bcnt_nxt = bcnt_r + BCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      bcnt_r     <= '0;
      chk_r      <= '0;
      sum_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      bcnt_r     <= bcnt_nxt;
      chk_r      <= chk_nxt;
      sum_r      <= sum_nxt;
    end
  end

  a_bcnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= BCNT_W'(PAYLOAD_DEPTH + 1))
    else $error("byte count beyond saturation");

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_push && cmd.op == CMD_EMIT) |=> !in_frame_r)
    else $error("frame still open after emit");

  a_no_cmd_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> (frame_enable_r && in_frame_r))
    else $error("command issued outside an enabled frame");

endmodule

`default_nettype wire

// File: hw/rtl/csdfr_cmd_q.sv
// Short command queue between the front end and the back end.
`default_nettype none

module csdfr_cmd_q
  import csdfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  cmd_t      wr_cmd,
  output logic      full,
  output logic      rd_valid,
  output cmd_t      rd_cmd,
  input  wire logic rd_en
);

  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr_r, rptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  do_wr, do_rd;

  assign full     = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = q_r[rptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + CMDQ_PTR_W'(1);
      if (do_rd) rptr_r <= rptr_r + CMDQ_PTR_W'(1);
      cnt_r <= cnt_r + CMDQ_CNT_W'(do_wr) - CMDQ_CNT_W'(do_rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("command word pushed into full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH)) |-> (wptr_r == rptr_r))
    else $error("command queue pointers out of step");

endmodule

`default_nettype wire

// File: hw/rtl/csdfr_back.sv
// Back end: payload store, frame read-out sequencer and result queue.
`default_nettype none

module csdfr_back
  import csdfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output res_t      res,
  output logic      empty,
  input  wire logic pop
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_r, state_nxt;
  logic [ECNT_W-1:0] emit_total_r, emit_total_nxt;
  logic [ECNT_W-1:0] emit_idx_r, emit_idx_nxt;

  logic [6:0]        mem [PAYLOAD_DEPTH];
  logic              wr_en;
  logic              rd_en;
  logic              rd_last;
  logic              credit;

  logic              rd_valid_r;
  logic [6:0]        rd_data_r;
  logic [ECNT_W-1:0] rd_idx_r;
  logic              rd_last_r;

  res_t                  outq_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] owptr_r, orptr_r;
  logic [OUTQ_CNT_W-1:0] ocnt_r;
  logic                  out_pop;

  // a read may be in flight, so reserve its slot in the result queue
  assign credit  = (ocnt_r + OUTQ_CNT_W'(rd_valid_r)) < OUTQ_CNT_W'(OUTQ_DEPTH);
  assign rd_last = (emit_idx_r == (emit_total_r - ECNT_W'(1)));

  always_comb begin
    state_nxt      = state_r;
    emit_total_nxt = emit_total_r;
    emit_idx_nxt   = emit_idx_r;
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == CMD_WRITE) begin
            wr_en = 1'b1;
          end else begin
            emit_total_nxt = cmd.count;
            emit_idx_nxt   = '0;
            state_nxt      = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (credit) begin
          rd_en        = 1'b1;
          emit_idx_nxt = emit_idx_r + ECNT_W'(1);
          if (rd_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    emit_total_r <= emit_total_nxt;
    emit_idx_r   <= emit_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.addr] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[emit_idx_r[ADDR_W-1:0]];
      rd_idx_r  <= emit_idx_r;
      rd_last_r <= rd_last;
    end
  end

  // result queue
  assign empty   = (ocnt_r == '0);
  assign res     = outq_r[orptr_r];
  assign out_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      outq_r[owptr_r] <= '{data: rd_data_r, index: 6'(rd_idx_r), last: rd_last_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (rd_valid_r) owptr_r <= owptr_r + OUTQ_PTR_W'(1);
      if (out_pop)    orptr_r <= orptr_r + OUTQ_PTR_W'(1);
      ocnt_r <= ocnt_r + OUTQ_CNT_W'(rd_valid_r) - OUTQ_CNT_W'(out_pop);
    end
  end

  a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r + OUTQ_CNT_W'(rd_valid_r)) <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue overcommitted");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (emit_total_r != '0 && emit_idx_r < emit_total_r))
    else $error("read-out index out of range");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |=> !empty)
    else $error("read data lost");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !cmd_pop)
    else $error("command taken during read-out");

endmodule

`default_nettype wire

// File: hw/rtl/checksummed_serial_deframer.sv
// Top level of the checksummed serial deframer.
// Received bytes are taken one per cycle while full is low; each payload byte
// becomes a store command and a verified stop byte an emit command, held in a
// four-word command queue. The back end writes each store command when popped
// and, for a verified frame of N payload bytes, reads the store once per cycle
// while the result queue has room. Once the emit command heads the command
// queue, results pass the state register, read register and result queue
// and stream one word per cycle while popped (four-word result queue).
// Bytes keep being accepted during read-out until the command queue fills.
// The store holds 32 payload bytes; further bytes overwrite the last one.
`default_nettype none

module checksummed_serial_deframer
  import csdfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            in_rx_byte,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [6:0]                 out_payload_byte,
  output logic [5:0]                 out_byte_index,
  output logic                       out_last_byte
);

  logic byte_acc;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;
  res_t res;

  assign byte_acc = push && !full;

  csdfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .byte_acc  (byte_acc),
    .rx_byte   (in_rx_byte),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  csdfr_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_push),
    .wr_cmd   (cmd_in),
    .full     (full),
    .rd_valid (cmd_valid),
    .rd_cmd   (cmd_head),
    .rd_en    (cmd_pop)
  );

  csdfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .empty     (empty),
    .pop       (pop)
  );

  assign out_payload_byte = res.data;
  assign out_byte_index   = res.index;
  assign out_last_byte    = res.last;

endmodule

`default_nettype wire

// File: test/tb_checksummed_serial_deframer.sv
// Testbench for the checksummed serial deframer: directed table, random frames, scoreboard.
`timescale 1ns / 100ps

module tb_checksummed_serial_deframer;
  import csdfr_pkg::*;

  localparam int SETTLE     = 16;   // cycles for the command and result queues to drain
  localparam int IDLE_LIMIT = 1000; // cycles without any handshake before giving up
  localparam int PHASES     = 8;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           val;
    int                   n_typed;  // -1: take the predictor's words
    logic [6:0]           t_data;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [6:0]            out_payload_byte;
  logic [5:0]            out_byte_index;
  logic                  out_last_byte;

  checksummed_serial_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last_byte    (out_last_byte)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // deframer mirror: registers and frame state
  logic       m_enable = 1'b0;
  logic [7:0] m_start  = START_CODE_RST;
  logic [7:0] m_stop   = STOP_CODE_RST;
  logic       open_q   = 1'b0;
  logic [6:0] count_q  = '0;
  logic [6:0] cksum_q  = '0;
  logic [7:0] sum_q    = '0;
  logic [6:0] store_q [PAYLOAD_DEPTH];

  res_t frame_words[$];    // words released by the byte just taken
  res_t pending_words[$];  // words the block still owes

  int         typed_n = -1;
  logic [6:0] typed_d = '0;
  int         burst_left = 0;
  int         fails = 0;
  int         bytes_sent = 0;
  int         words_seen = 0;
  int         frames_seen = 0;
  int         cfg_writes = 0;
  int         idle_cycles = 0;

  plan_row_t plan[$];

  // one received byte through the deframer; verified frames land in frame_words
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] t;
    logic [6:0] want;
    int         n;
    int         slot;
    res_t       w;
    if (m_enable) begin
      if (b[7]) begin
        if (b == m_start) begin
          sum_q   = '0;
          count_q = '0;
          cksum_q = '0;
          open_q  = 1'b1;
        end else if (b == m_stop && open_q) begin
          t      = sum_q + 8'd1;
          want   = ~t[6:0];
          open_q = 1'b0;
          if (cksum_q == want && count_q > 7'd1) begin
            n = int'(count_q) - 1;
            if (n > PAYLOAD_DEPTH) n = PAYLOAD_DEPTH;
            for (int i = 0; i < n; i++) begin
              w.data  = store_q[i];
              w.index = 6'(i);
              w.last  = (i == n - 1);
              frame_words.push_back(w);
            end
          end
        end
      end else if (open_q) begin
        if (count_q == 7'd0) begin
          cksum_q = b[6:0];
        end else begin
          slot = int'(count_q) - 1;
          if (slot > PAYLOAD_DEPTH - 1) slot = PAYLOAD_DEPTH - 1;
          store_q[slot] = b[6:0];
          sum_q = sum_q + b;
        end
        if (count_q < 7'(PAYLOAD_DEPTH + 1)) count_q = count_q + 7'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // called at a falling edge; returns at a falling edge with nothing assigned there
  task automatic send_byte(input logic [7:0] b, input int n_typed, input logic [6:0] d);
    push       <= 1'b1;
    in_rx_byte <= b;
    typed_n     = n_typed;
    typed_d     = d;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(20, 40);
    end else begin
      burst_left--;
    end
  endtask

  // registers only change once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    push <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_FRAME_ENABLE: m_enable = val[0];
      REG_START_CODE:   m_start  = val;
      REG_STOP_CODE:    m_stop   = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  function automatic plan_row_t byte_row(logic [7:0] b, int n, logic [6:0] d);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.idx     = '0;
    r.val     = b;
    r.n_typed = n;
    r.t_data  = d;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    plan_row_t r;
    r.is_cfg  = 1'b1;
    r.idx     = idx;
    r.val     = v;
    r.n_typed = -1;
    r.t_data  = '0;
    return r;
  endfunction

  // receiver: random 8-step pop pattern, never all stalls
  logic [7:0] pop_pat = 8'hff;
  int         pat_left = 0;
  int         pat_pos = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pop_pat  = ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom()) | 8'h01);
        pat_left = 32;
      end
      pat_left--;
      pop <= pop_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 8;
    end
  end

  // sampling, prediction, scoreboard and watchdog
  always @(posedge clk) begin
    res_t w;
    res_t got;
    bit   moved;
    if (rst_n) begin
      moved = 1'b0;
      if (push && !full) begin
        moved = 1'b1;
        frame_words.delete();
        deframe_byte(in_rx_byte);
        if (typed_n >= 0) begin
          if (typed_n > 0) begin
            w.data  = typed_d;
            w.index = 6'd0;
            w.last  = 1'b1;
            pending_words.push_back(w);
          end
        end else begin
          foreach (frame_words[i]) pending_words.push_back(frame_words[i]);
        end
      end
      if (pop && !empty) begin
        moved = 1'b1;
        words_seen++;
        if (out_last_byte) frames_seen++;
        if (pending_words.size() == 0) begin
          $error("unexpected word: payload_byte %0h byte_index %0d last_byte %0b",
                 out_payload_byte, out_byte_index, out_last_byte);
          fails++;
        end else begin
          got = pending_words.pop_front();
          check_field("payload_byte", got.data, out_payload_byte);
          check_field("byte_index", got.index, out_byte_index);
          check_field("last_byte", got.last, out_last_byte);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, %0d words still owed",
                 IDLE_LIMIT, pending_words.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] st_v;
    logic [7:0] sp_v;
    logic [7:0] b_v;
    logic [7:0] sum_v;
    logic [7:0] t_v;
    logic [7:0] frame_q[$];
    logic       en_v;
    int         budget;
    int         sent_ph;
    int         n_pay;
    int         r;

    // reset state: block disabled
    plan.push_back(byte_row(8'h80, 0, 7'h00));
    plan.push_back(byte_row(8'h7e, 0, 7'h00));
    plan.push_back(byte_row(8'h00, 0, 7'h00));
    plan.push_back(byte_row(8'h81, 0, 7'h00));
    plan.push_back(cfg_row(REG_FRAME_ENABLE, 8'h01));
    // stop and data with no frame open
    plan.push_back(byte_row(8'h81, 0, 7'h00));
    plan.push_back(byte_row(8'h55, 0, 7'h00));
    // smallest payload value
    plan.push_back(byte_row(8'h80, -1, 7'h00));
    plan.push_back(byte_row(8'h7e, -1, 7'h00));
    plan.push_back(byte_row(8'h00, -1, 7'h00));
    plan.push_back(byte_row(8'h81, 1, 7'h00));
    // largest payload value, with a stray high byte inside
    plan.push_back(byte_row(8'h80, -1, 7'h00));
    plan.push_back(byte_row(8'h7f, -1, 7'h00));
    plan.push_back(byte_row(8'h7f, -1, 7'h00));
    plan.push_back(byte_row(8'hff, -1, 7'h00));
    plan.push_back(byte_row(8'h81, 1, 7'h7f));
    // start inside a frame restarts it
    plan.push_back(byte_row(8'h80, -1, 7'h00));
    plan.push_back(byte_row(8'h12, -1, 7'h00));
    plan.push_back(byte_row(8'h80, -1, 7'h00));
    plan.push_back(byte_row(8'h7e, -1, 7'h00));
    plan.push_back(byte_row(8'h00, -1, 7'h00));
    plan.push_back(byte_row(8'h81, 1, 7'h00));
    // bad checksum
    plan.push_back(byte_row(8'h80, -1, 7'h00));
    plan.push_back(byte_row(8'h00, -1, 7'h00));
    plan.push_back(byte_row(8'h05, -1, 7'h00));
    plan.push_back(byte_row(8'h81, 0, 7'h00));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else send_byte(plan[i].val, plan[i].n_typed, plan[i].t_data);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      budget = 40;
      case (ph)
        0: begin en_v = 1'b1; st_v = 8'h80; sp_v = 8'h81; end
        1: begin en_v = 1'b1; st_v = 8'hff; sp_v = 8'h80; end
        2: begin en_v = 1'b1; st_v = 8'h80; sp_v = 8'hff; end
        3: begin en_v = 1'b1; st_v = 8'ha5; sp_v = 8'ha5; budget = 20; end
        // codes below the high range are plain data
        4: begin en_v = 1'b1; st_v = 8'h7f; sp_v = 8'h00; budget = 20; end
        5: begin en_v = 1'b0; st_v = 8'h9b; sp_v = 8'h9c; budget = 15; end
        6: begin
          en_v = 1'b1;
          st_v = 8'($urandom_range(128, 255));
          sp_v = 8'($urandom_range(128, 255));
          while (sp_v == st_v) sp_v = 8'($urandom_range(128, 255));
        end
        default: begin en_v = 1'b1; st_v = START_CODE_RST; sp_v = STOP_CODE_RST; end
      endcase
      write_reg(REG_FRAME_ENABLE, {7'd0, en_v});
      write_reg(REG_START_CODE, st_v);
      write_reg(REG_STOP_CODE, sp_v);

      sent_ph = 0;
      while (sent_ph < budget) begin
        frame_q.delete();
        if ($urandom_range(0, 9) < 8) begin
          // well-formed frame, mostly short, now and then past the store
          n_pay = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
          sum_v = '0;
          frame_q.push_back(st_v);
          frame_q.push_back(8'h00);
          for (int k = 0; k < n_pay; k++) begin
            b_v   = 8'($urandom_range(0, 127));
            sum_v = sum_v + b_v;
            frame_q.push_back(b_v);
            if ($urandom_range(0, 15) == 0) begin
              b_v = 8'($urandom_range(128, 255));
              while (b_v == st_v || b_v == sp_v) b_v = 8'($urandom_range(128, 255));
              frame_q.push_back(b_v);
            end
          end
          t_v = sum_v + 8'd1;
          frame_q[1] = {1'b0, ~t_v[6:0]};
          if ($urandom_range(0, 9) == 0) frame_q[1] = 8'($urandom_range(0, 127));
          frame_q.push_back(sp_v);
        end else begin
          // noise, heavy on the codes so broken frames turn up
          repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 5);
            b_v = (r == 0) ? st_v : (r == 1) ? sp_v : 8'($urandom_range(0, 255));
            frame_q.push_back(b_v);
          end
        end
        foreach (frame_q[k]) send_byte(frame_q[k], -1, 7'h00);
        sent_ph += frame_q.size();
      end
    end

    push <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("%0d bytes sent across %0d register writes", bytes_sent, cfg_writes);
    $display("%0d payload words checked in %0d verified frames", words_seen, frames_seen);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
